// File: hw/rtl/fsh_pkg.sv
// package: types, constants and helpers for the floyd-steinberg halftone core
`timescale 1ns / 1ps

package fsh_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int CHANNELS   = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;
  localparam int WIDTH_W    = 11;
  localparam int CMP_W      = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int CFG_DATA_W = 16;
  localparam int ACC_W      = 20;
  localparam int WIDE_W     = ACC_W + 2;
  localparam int PROD_W     = ACC_W + 4;

  typedef logic [COL_W-1:0]          col_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef acc_t [CHANNELS-1:0]       line_t;

  localparam acc_t  THRESHOLD = acc_t'(32640);
  localparam acc_t  FULL_INK  = acc_t'(65280);
  localparam wide_t ACC_MAX   = wide_t'(524287);
  localparam wide_t ACC_MIN   = -wide_t'(524288);

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } in_t;

  typedef struct packed {
    logic red_dot;
    logic green_dot;
    logic blue_dot;
    logic row_end;
    logic frame_end;
  } out_t;

  typedef struct packed {
    logic col_nz;
    logic row_nz;
    logic last_col;
    logic last_row;
  } pix_ctl_t;

  typedef struct packed {
    logic dot;
    acc_t right_nxt;
    acc_t diag_nxt;
    acc_t line_nxt;
    acc_t wr_data;
  } chan_res_t;

  function automatic acc_t sat20(input wide_t v);
    acc_t r;
    if (v > ACC_MAX) begin
      r = acc_t'(ACC_MAX);
    end else if (v < ACC_MIN) begin
      r = acc_t'(ACC_MIN);
    end else begin
      r = acc_t'(v);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/fsh_chan.sv
// one color channel: threshold decision and error shares for one pixel
`timescale 1ns / 1ps

module fsh_chan (
  input  logic              [7:0] level,
  input  fsh_pkg::acc_t           right_carry,
  input  fsh_pkg::acc_t           diag_carry,
  input  fsh_pkg::acc_t           below_raw,
  input  fsh_pkg::acc_t           line_prev,
  input  fsh_pkg::pix_ctl_t       ctl,
  output fsh_pkg::chan_res_t      res
);
  import fsh_pkg::*;

  logic [7:0] ink;
  wide_t      base;
  wide_t      acc;
  acc_t       sum;
  logic       dot;
  acc_t       err;
  prod_t      err_w;
  prod_t      e7;
  prod_t      e5;
  prod_t      e3;
  acc_t       q7;
  acc_t       q5;
  acc_t       q3;
  acc_t       q1;

  assign ink   = 8'hFF - level;
  assign base  = wide_t'({{(WIDE_W - 16){1'b0}}, ink, 8'h00});
  assign acc   = base + wide_t'(right_carry) + (ctl.row_nz ? wide_t'(below_raw) : '0);
  assign sum   = sat20(acc);
  assign dot   = (sum >= THRESHOLD);
  assign err   = dot ? sum - FULL_INK : sum;

  assign err_w = prod_t'(err);
  assign e7    = (err_w <<< 3) - err_w;
  assign e5    = (err_w <<< 2) + err_w;
  assign e3    = (err_w <<< 1) + err_w;
  assign q7    = acc_t'(e7 >>> 4);
  assign q5    = acc_t'(e5 >>> 4);
  assign q3    = acc_t'(e3 >>> 4);
  assign q1    = acc_t'(err_w >>> 4);

  always_comb begin
    res.dot       = dot;
    res.right_nxt = ctl.last_col ? '0 : q7;
    res.diag_nxt  = ctl.last_col ? '0 : q1;
    res.line_nxt  = ctl.last_row ? below_raw : sat20(wide_t'(diag_carry) + wide_t'(q5));
    res.wr_data   = (ctl.col_nz && !ctl.last_row) ?
                    sat20(wide_t'(line_prev) + wide_t'(q3)) : line_prev;
  end

endmodule

// File: hw/rtl/floyd_steinberg_halftone_core.sv
// top level: floyd-steinberg error diffusion halftoning of an rgb pixel stream
//
// pixels enter in raster order on the in_ channel (valid/stall) and leave as
// one dot per channel plus row_end and frame_end on the out_ channel.
// a transaction takes place at a clock edge with valid high and stall low.
// a pixel accepted at the input waits in stage b, then is registered in the
// output register that drives out_valid. throughput: one pixel per cycle
// while in_stall stays low; the right-carry feedback (add, saturate,
// threshold, 7/16 share) is combinational from rc_r back to rc_r, and the
// row-below error line lives in one 1024-entry memory written once and read
// once per pixel. the entry left of the current column is held in a register
// until its last share arrives; short rows are covered by forwarding around
// the memory. after reset the line memory is cleared entry by entry, with
// in_stall high; configuration writes are taken during that time.
// when the receiver stalls, the output register holds its transaction, one more
// pixel waits in the internal stage, and in_stall rises. image_width (index 0)
// and image_height (index 1) are written on the cfg_ port, by the user only
// while no pixel is in flight, unenforced by the block; reset values 512, 512.

`timescale 1ns / 1ps

module floyd_steinberg_halftone_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fsh_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fsh_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  fsh_pkg::cfg_idx_t                cfg_index,
  input  logic [fsh_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fsh_pkg::*;

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  col_t               col_r;
  logic [ROW_W-1:0]   row_r;
  logic               clr_busy_r;
  col_t               clr_addr_r;

  logic               b_valid_r;
  in_t                b_data_r;
  col_t               b_x_r;
  pix_ctl_t           b_ctl_r;
  logic               b_fwd_r;
  line_t              rd_r;
  line_t              l_val_r;
  col_t               l_idx_r;
  line_t              w_data_r;
  line_t              rc_r;
  line_t              dg_r;
  logic               out_valid_r;
  out_t               out_data_r;

  line_t              mem [MAX_WIDTH];

  logic               accept;
  logic               b_fire;
  logic [CMP_W-1:0]   w_eff;
  logic [CMP_W-1:0]   x_p1;
  logic [ROW_W-1:0]   h_eff;
  logic               last_col;
  logic               last_row;
  pix_ctl_t           ctl_nxt;
  line_t              below_raw;
  line_t              wr_line;
  line_t              line_nxt;
  line_t              rc_nxt;
  line_t              dg_nxt;
  logic [CHANNELS-1:0] dot;
  logic [7:0]         lvl [CHANNELS];
  chan_res_t          res [CHANNELS];
  out_t               out_nxt;
  logic               mem_we;
  col_t               mem_waddr;
  line_t              mem_wdata;

  assign b_fire   = b_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (b_valid_r && !b_fire);
  assign accept   = in_valid && !in_stall;

  // position of the incoming pixel
  always_comb begin
    if (width_r == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(width_r);
    end
    h_eff    = (height_r == '0) ? ROW_W'(1) : height_r;
    x_p1     = CMP_W'(col_r) + CMP_W'(1);
    last_col = (x_p1 >= w_eff);
    last_row = ((17'(row_r) + 17'd1) >= 17'(h_eff));
    ctl_nxt.col_nz   = (col_r != '0);
    ctl_nxt.row_nz   = (row_r != '0);
    ctl_nxt.last_col = last_col;
    ctl_nxt.last_row = last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(512);
      height_r <= ROW_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + col_t'(1);
        if (clr_addr_r == col_t'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + col_t'(1);
        end
      end
    end
  end

  // line memory: at most one write and one registered read per cycle
  assign mem_we    = clr_busy_r || b_fire;
  assign mem_waddr = clr_busy_r ? clr_addr_r : l_idx_r;
  assign mem_wdata = clr_busy_r ? line_t'('0) : wr_line;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_r <= mem[col_r];
    end
  end

  // stage b: pixel with its line entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_fwd_r   <= 1'b0;
    end else begin
      if (accept) begin
        b_valid_r <= 1'b1;
        b_fwd_r   <= b_fire && (l_idx_r == col_r);
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_data_r <= in_data;
      b_x_r    <= col_r;
      b_ctl_r  <= ctl_nxt;
    end
  end

  // newest copy of the entry under the current column
  always_comb begin
    if (b_x_r == l_idx_r) begin
      below_raw = l_val_r;
    end else if (b_fwd_r) begin
      below_raw = w_data_r;
    end else begin
      below_raw = rd_r;
    end
  end

  genvar gc;
  generate
    for (gc = 0; gc < CHANNELS; gc++) begin : g_chan
      if (gc == 0) begin : g_red
        assign lvl[gc] = b_data_r.red_level;
      end else if (gc == 1) begin : g_green
        assign lvl[gc] = b_data_r.green_level;
      end else if (gc == 2) begin : g_blue
        assign lvl[gc] = b_data_r.blue_level;
      end else begin : g_fixed
        assign lvl[gc] = 8'hFF;
      end

      fsh_chan u_chan (
        .level       (lvl[gc]),
        .right_carry (rc_r[gc]),
        .diag_carry  (dg_r[gc]),
        .below_raw   (below_raw[gc]),
        .line_prev   (l_val_r[gc]),
        .ctl         (b_ctl_r),
        .res         (res[gc])
      );

      assign wr_line[gc]  = res[gc].wr_data;
      assign line_nxt[gc] = res[gc].line_nxt;
      assign rc_nxt[gc]   = res[gc].right_nxt;
      assign dg_nxt[gc]   = res[gc].diag_nxt;
      assign dot[gc]      = res[gc].dot;
    end
  endgenerate

  always_comb begin
    out_nxt.red_dot   = !dot[0];
    out_nxt.green_dot = !dot[1];
    out_nxt.blue_dot  = !dot[2];
    out_nxt.row_end   = b_ctl_r.last_col;
    out_nxt.frame_end = b_ctl_r.last_col && b_ctl_r.last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= '0;
      dg_r        <= '0;
      l_val_r     <= '0;
      l_idx_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_fire) begin
        rc_r        <= rc_nxt;
        dg_r        <= dg_nxt;
        l_val_r     <= line_nxt;
        l_idx_r     <= b_x_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      w_data_r   <= wr_line;
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
